// File: design/matrix_determinant_core_defines.svh
// assertion macros of the matrix determinant core
// expects signals named clk and rst in the scope where a macro is used
`ifndef MATRIX_DETERMINANT_CORE_DEFINES_SVH
`define MATRIX_DETERMINANT_CORE_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define MDC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define MDC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/mdc_pkg.sv
// shared types, constants and the permutation table of the matrix determinant core
// no dependencies
package mdc_pkg;

  localparam int ORDER_W   = 3;
  localparam int COUNT_W   = 5;
  localparam int TERM_W    = 5;
  localparam int ELEM_W    = 16;
  localparam int DET_W     = 64;

  localparam logic [ORDER_W-1:0] ORDER_RESET = 3'd4;

  localparam logic [DET_W-1:0] DET_MAX = {1'b0, {(DET_W-1){1'b1}}};
  localparam logic [DET_W-1:0] DET_MIN = {1'b1, {(DET_W-1){1'b0}}};

  // phase of a term = row whose element is being read
  localparam logic [1:0] PH_ROW0 = 2'd0;
  localparam logic [1:0] PH_ROW1 = 2'd1;
  localparam logic [1:0] PH_ROW2 = 2'd2;
  localparam logic [1:0] PH_ROW3 = 2'd3;

  typedef struct packed {
    logic            neg;
    logic [3:0][1:0] col;
  } perm_t;

  typedef struct packed {
    logic [1:0] phase;
    logic       cur;
    logic       prev;
    logic       clr;
    logic       neg;
    logic       pad;
    logic       done;
  } mdc_ctl_t;

  function automatic perm_t mk_perm(logic neg, logic [1:0] c0, logic [1:0] c1,
                                    logic [1:0] c2, logic [1:0] c3);
    perm_t p;
    p.neg = neg;
    p.col = {c3, c2, c1, c0};
    return p;
  endfunction

  // the first k! entries permute columns 0..k-1 and leave the rest in place
  function automatic perm_t perm_lookup(logic [TERM_W-1:0] t);
    perm_t p;
    case (t)
      5'd0:    p = mk_perm(1'b0, 2'd0, 2'd1, 2'd2, 2'd3);
      5'd1:    p = mk_perm(1'b1, 2'd1, 2'd0, 2'd2, 2'd3);
      5'd2:    p = mk_perm(1'b1, 2'd0, 2'd2, 2'd1, 2'd3);
      5'd3:    p = mk_perm(1'b0, 2'd1, 2'd2, 2'd0, 2'd3);
      5'd4:    p = mk_perm(1'b1, 2'd2, 2'd1, 2'd0, 2'd3);
      5'd5:    p = mk_perm(1'b0, 2'd2, 2'd0, 2'd1, 2'd3);
      5'd6:    p = mk_perm(1'b1, 2'd0, 2'd1, 2'd3, 2'd2);
      5'd7:    p = mk_perm(1'b0, 2'd1, 2'd0, 2'd3, 2'd2);
      5'd8:    p = mk_perm(1'b0, 2'd0, 2'd2, 2'd3, 2'd1);
      5'd9:    p = mk_perm(1'b1, 2'd1, 2'd2, 2'd3, 2'd0);
      5'd10:   p = mk_perm(1'b0, 2'd2, 2'd1, 2'd3, 2'd0);
      5'd11:   p = mk_perm(1'b1, 2'd2, 2'd0, 2'd3, 2'd1);
      5'd12:   p = mk_perm(1'b1, 2'd0, 2'd3, 2'd2, 2'd1);
      5'd13:   p = mk_perm(1'b0, 2'd1, 2'd3, 2'd2, 2'd0);
      5'd14:   p = mk_perm(1'b0, 2'd0, 2'd3, 2'd1, 2'd2);
      5'd15:   p = mk_perm(1'b1, 2'd1, 2'd3, 2'd0, 2'd2);
      5'd16:   p = mk_perm(1'b0, 2'd2, 2'd3, 2'd0, 2'd1);
      5'd17:   p = mk_perm(1'b1, 2'd2, 2'd3, 2'd1, 2'd0);
      5'd18:   p = mk_perm(1'b1, 2'd3, 2'd1, 2'd2, 2'd0);
      5'd19:   p = mk_perm(1'b0, 2'd3, 2'd0, 2'd2, 2'd1);
      5'd20:   p = mk_perm(1'b0, 2'd3, 2'd2, 2'd1, 2'd0);
      5'd21:   p = mk_perm(1'b1, 2'd3, 2'd2, 2'd0, 2'd1);
      5'd22:   p = mk_perm(1'b0, 2'd3, 2'd1, 2'd0, 2'd2);
      5'd23:   p = mk_perm(1'b1, 2'd3, 2'd0, 2'd1, 2'd2);
      default: p = mk_perm(1'b0, 2'd0, 2'd1, 2'd2, 2'd3);
    endcase
    return p;
  endfunction

  // index of the last permutation term, n! - 1
  function automatic logic [TERM_W-1:0] last_term(logic [ORDER_W-1:0] n);
    logic [TERM_W-1:0] v;
    case (n)
      3'd2:    v = 5'd1;
      3'd3:    v = 5'd5;
      3'd4:    v = 5'd23;
      default: v = 5'd0;
    endcase
    return v;
  endfunction

endpackage

// File: design/matrix_determinant_core.sv
// top level of the matrix determinant core: element store, sequencer and datapath
// depends on mdc_pkg, mdc_store, mdc_ctrl and mdc_datapath
//
//   channel   handshake              payload
//   cfg       cfg_we                 cfg_wdata (matrix order)
//   in        in_valid / in_stall    element_value, row-major
//   out       out_valid / out_stall  determinant, overflow
//
// loading takes one element per cycle while in_stall is low, n*n elements for an order-n matrix
// then the sequencer steps through phases PH_ROW0 to PH_ROW3 of every permutation term, at most one store read
// and one pass through the shared 32x32 multiplier per cycle; input is stalled then
// the result sits in an output register; the next matrix may load while it waits
// synchronous reset sets the order to 4 and empties the load count, store contents stay
module matrix_determinant_core #(
  parameter int MAX_ORDER    = 4,
  parameter int ELEMENT_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [mdc_pkg::ORDER_W-1:0]       cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [mdc_pkg::ELEM_W-1:0] element_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [mdc_pkg::DET_W-1:0]  determinant,
  output logic                              overflow
);

  import mdc_pkg::*;

  localparam int DEPTH  = MAX_ORDER * MAX_ORDER;
  localparam int ADDR_W = $clog2(DEPTH);

  logic                    wr_en;
  logic [ADDR_W-1:0]       wr_addr;
  logic                    rd_en;
  logic [ADDR_W-1:0]       rd_addr;
  logic [ELEMENT_BITS-1:0] rd_data;
  mdc_ctl_t                ctl;

  mdc_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (ELEMENT_BITS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (element_value[ELEMENT_BITS-1:0]),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  mdc_ctrl #(
    .MAX_ORDER (MAX_ORDER),
    .ADDR_W    (ADDR_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .ctl       (ctl)
  );

  mdc_datapath #(
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_datapath (
    .clk         (clk),
    .ctl         (ctl),
    .rd_data     (rd_data),
    .determinant (determinant),
    .overflow    (overflow)
  );

endmodule

// File: design/mdc_store.sv
// element store of the matrix determinant core
// one write port, one read port with registered read data, no dependencies
module mdc_store #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: design/mdc_ctrl.sv
// load counter, order register and term sequencer of the matrix determinant core
// depends on mdc_pkg and matrix_determinant_core_defines.svh
`include "matrix_determinant_core_defines.svh"

module mdc_ctrl #(
  parameter int MAX_ORDER = 4,
  parameter int ADDR_W    = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [mdc_pkg::ORDER_W-1:0]  cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_stall,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         wr_en,
  output logic [ADDR_W-1:0]            wr_addr,
  output logic                         rd_en,
  output logic [ADDR_W-1:0]            rd_addr,
  output mdc_pkg::mdc_ctl_t            ctl
);

  import mdc_pkg::*;

  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  localparam logic [ORDER_W-1:0] MAX_N = ORDER_W'(MAX_ORDER);

  logic [1:0]         state, state_next;
  logic [ORDER_W-1:0] order;
  logic [ORDER_W-1:0] n;
  logic [COUNT_W-1:0] load_count;
  logic [COUNT_W-1:0] total;
  logic [COUNT_W-1:0] idx;
  logic [TERM_W-1:0]  term;
  logic [TERM_W-1:0]  last;
  logic [1:0]         phase;
  logic               pad_d;
  logic               in_accept;
  logic               row_pad;
  logic               done;
  logic               load_last;
  perm_t              perm;

  always_comb begin
    if (order == '0) begin
      n = ORDER_W'(1);
    end else if (order > MAX_N) begin
      n = MAX_N;
    end else begin
      n = order;
    end
  end

  assign total     = COUNT_W'(n) * COUNT_W'(n);
  assign last      = last_term(n);
  assign in_stall  = (state != ST_LOAD) | cfg_we;
  assign in_accept = in_valid & ~in_stall;
  assign load_last = load_count == (total - COUNT_W'(1));
  assign wr_en     = in_accept;
  assign wr_addr   = load_count[ADDR_W-1:0];

  // row r of term t sits at r*n + perm(t, r); rows at or past n read as one
  assign perm    = perm_lookup(term);
  assign idx     = COUNT_W'(phase) * COUNT_W'(n) + COUNT_W'(perm.col[phase]);
  assign row_pad = ORDER_W'(phase) >= n;
  assign rd_en   = (state == ST_RUN) & ~row_pad;
  assign rd_addr = idx[ADDR_W-1:0];

  assign done = (state == ST_DONE) & (~out_valid | ~out_stall);

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (in_accept && load_last) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (phase == PH_ROW3 && term == last) state_next = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (phase == PH_ROW2) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (done) state_next = ST_LOAD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      order      <= ORDER_RESET;
      load_count <= '0;
      term       <= '0;
      phase      <= PH_ROW0;
      pad_d      <= 1'b1;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        order      <= cfg_wdata;
        load_count <= '0;
      end else if (in_accept) begin
        load_count <= load_last ? '0 : load_count + COUNT_W'(1);
      end
      if (state == ST_RUN || state == ST_FLUSH) begin
        phase <= phase + 2'd1;
      end else begin
        phase <= PH_ROW0;
      end
      if (state == ST_LOAD) begin
        term <= '0;
      end else if (state == ST_RUN && phase == PH_ROW3) begin
        term <= term + TERM_W'(1);
      end
      pad_d     <= row_pad | (state != ST_RUN);
      out_valid <= done | (out_valid & out_stall);
    end
  end

  // the product pipeline trails the reads: a term finishes in phase PH_ROW2 of the next term or of the flush
  always_comb begin
    ctl.phase = phase;
    ctl.cur   = state == ST_RUN;
    ctl.prev  = (state == ST_RUN && term != '0) || state == ST_FLUSH;
    ctl.clr   = state == ST_RUN && term == '0 && phase == PH_ROW0;
    ctl.neg   = perm.neg;
    ctl.pad   = pad_d;
    ctl.done  = done;
  end

  `MDC_ASSERT_NOW(a_count_bound, state == ST_LOAD, load_count < total, "load count past matrix size")
  `MDC_ASSERT_NOW(a_term_bound, state == ST_RUN, term <= last, "term index past last permutation")
  `MDC_ASSERT_NEXT(a_run_after_last, in_accept && load_last, state == ST_RUN, "no run after last element")
  `MDC_ASSERT_NOW(a_result_from_done, $rose(out_valid), $past(state) == ST_DONE, "result without run")

endmodule

// File: design/mdc_datapath.sv
// shared multiplier, exact accumulator and saturating output register
// depends on mdc_pkg
module mdc_datapath #(
  parameter int ELEMENT_BITS = 16
) (
  input  logic                              clk,
  input  mdc_pkg::mdc_ctl_t                 ctl,
  input  logic [ELEMENT_BITS-1:0]           rd_data,
  output logic signed [mdc_pkg::DET_W-1:0]  determinant,
  output logic                              overflow
);

  import mdc_pkg::*;

  localparam int EB    = ELEMENT_BITS;
  localparam int PW    = 2 * EB;
  localparam int FW    = 4 * EB;
  localparam int ACC_W = FW + TERM_W;
  localparam int EXT_W = (ACC_W > DET_W) ? ACC_W : DET_W + 1;

  logic signed [EB-1:0]     e;
  logic signed [EB-1:0]     x0, x2;
  logic signed [PW-1:0]     q01, q23;
  logic signed [PW-1:0]     mul_a, mul_b;
  logic signed [FW-1:0]     mul_p;
  logic signed [FW-1:0]     fp;
  logic                     fneg, neg_d;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  term_ext;
  logic signed [EXT_W-1:0]  acc_ext;
  logic [EXT_W-DET_W:0]     top_bits;
  logic                     fits;

  assign e = ctl.pad ? EB'(1) : rd_data;

  // one multiplier shared by the three products of a term
  always_comb begin
    case (ctl.phase)
      PH_ROW0: begin
        mul_a = PW'(x2);
        mul_b = PW'(e);
      end
      PH_ROW1: begin
        mul_a = q01;
        mul_b = q23;
      end
      default: begin
        mul_a = PW'(x0);
        mul_b = PW'(e);
      end
    endcase
  end

  assign mul_p    = FW'(mul_a) * FW'(mul_b);
  assign term_ext = ACC_W'(fp);

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      acc <= '0;
    end
    case (ctl.phase)
      PH_ROW0: begin
        if (ctl.prev) q23 <= mul_p[PW-1:0];
      end
      PH_ROW1: begin
        if (ctl.cur) x0 <= e;
        if (ctl.prev) begin
          fp   <= mul_p;
          fneg <= neg_d;
        end
      end
      PH_ROW2: begin
        if (ctl.cur) q01 <= mul_p[PW-1:0];
        if (ctl.prev) acc <= fneg ? acc - term_ext : acc + term_ext;
      end
      PH_ROW3: begin
        if (ctl.cur) begin
          x2    <= e;
          neg_d <= ctl.neg;
        end
      end
      default: ;
    endcase
  end

  // value fits when every bit from bit 63 upward equals the sign
  assign acc_ext  = EXT_W'(acc);
  assign top_bits = acc_ext[EXT_W-1:DET_W-1];
  assign fits     = (&top_bits) | ~(|top_bits);

  always_ff @(posedge clk) begin
    if (ctl.done) begin
      if (fits) begin
        determinant <= acc_ext[DET_W-1:0];
      end else begin
        determinant <= acc_ext[EXT_W-1] ? DET_MIN : DET_MAX;
      end
      overflow <= ~fits;
    end
  end

endmodule
